FILE: rtl/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W       = 5;
	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 32;
	localparam int CAP_RESET   = 16;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic                      action;
		logic signed [KEY_W-1:0]   key;
		logic signed [VALUE_W-1:0] value;
	} lfu_req_t;

	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] read_value;
		logic                      evicted;
		logic signed [KEY_W-1:0]   evicted_key;
	} lfu_rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} lfu_entry_t;

	localparam int ENTRY_W = $bits(lfu_entry_t);

	typedef struct packed {
		logic             touch;
		logic [IDX_W-1:0] touch_idx;
		logic [IDX_W-1:0] touch_rank;
		logic             remove;
		logic [IDX_W-1:0] remove_idx;
		logic [IDX_W-1:0] remove_rank;
		logic             insert;
		logic [IDX_W-1:0] insert_idx;
	} lfu_rank_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} lfu_state_t;

endpackage

FILE: rtl/lfu_entry_ram.sv
`timescale 1ns / 1ps

module lfu_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 96,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/lfu_rank_cells.sv
`timescale 1ns / 1ps

module lfu_rank_cells (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         upd,
	input  lfu_pkg::lfu_rank_cmd_t       cmd,
	input  logic [lfu_pkg::IDX_W-1:0]    rd_idx,
	output logic [lfu_pkg::IDX_W-1:0]    rd_rank,
	output logic [lfu_pkg::MAX_ENTRIES-1:0] valid,
	output logic [lfu_pkg::OCC_W-1:0]    occupancy
);

	logic [lfu_pkg::IDX_W-1:0]       rank_q [lfu_pkg::MAX_ENTRIES];
	logic [lfu_pkg::MAX_ENTRIES-1:0] valid_q;
	logic [lfu_pkg::OCC_W-1:0]       occ_q;
	logic [lfu_pkg::OCC_W-1:0]       occ_after_remove;
	logic [lfu_pkg::OCC_W-1:0]       occ_top;

	assign rd_rank   = rank_q[rd_idx];
	assign valid     = valid_q;
	assign occupancy = occ_q;

	assign occ_after_remove = cmd.remove ? (occ_q - lfu_pkg::OCC_W'(1)) : occ_q;
	assign occ_top          = occ_q - lfu_pkg::OCC_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (upd) begin
			for (int j = 0; j < lfu_pkg::MAX_ENTRIES; j++) begin
				if (cmd.remove && (cmd.remove_idx == lfu_pkg::IDX_W'(j))) begin
					valid_q[j] <= 1'b0;
				end
				if (cmd.insert && (cmd.insert_idx == lfu_pkg::IDX_W'(j))) begin
					valid_q[j] <= 1'b1;
				end
			end
			if (cmd.insert && !cmd.remove) begin
				occ_q <= occ_q + lfu_pkg::OCC_W'(1);
			end else if (cmd.remove && !cmd.insert) begin
				occ_q <= occ_q - lfu_pkg::OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			for (int j = 0; j < lfu_pkg::MAX_ENTRIES; j++) begin
				if (cmd.insert && (cmd.insert_idx == lfu_pkg::IDX_W'(j))) begin
					rank_q[j] <= occ_after_remove[lfu_pkg::IDX_W-1:0];
				end else if (cmd.touch && (cmd.touch_idx == lfu_pkg::IDX_W'(j))) begin
					rank_q[j] <= occ_top[lfu_pkg::IDX_W-1:0];
				end else if (valid_q[j] &&
					((cmd.touch && (rank_q[j] > cmd.touch_rank)) ||
					 (cmd.remove && (rank_q[j] > cmd.remove_rank)))) begin
					rank_q[j] <= rank_q[j] - lfu_pkg::IDX_W'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/lfu_cache_table.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  lfu_req_t (action, key, value)
// rsp       out        rsp_valid/rsp_stall  lfu_rsp_t (hit, read_value, evicted, evicted_key)
// cfg       in         cfg_we               cfg_data (capacity_in_use)
//
// A new request is taken only in the idle state, so transactions never overlap.
// The single read port of the entry memory is swept over all 16 entries, one per
// cycle, followed by a drain state and a commit state that writes back.
// Reset is asynchronous; it clears all valid bits, the occupancy and the FSM.
// A stalled response holds the commit until the output register is free.

module lfu_cache_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  lfu_pkg::lfu_req_t           req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output lfu_pkg::lfu_rsp_t           rsp,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]   cfg_data
);

	lfu_pkg::lfu_state_t state_q, state_d;

	logic [lfu_pkg::CAP_W-1:0]   cap_q;
	logic [lfu_pkg::OCC_W-1:0]   eff_cap;
	lfu_pkg::lfu_req_t           req_q;
	logic [lfu_pkg::IDX_W-1:0]   addr_q;
	logic                        rd_en;
	logic                        pend_s1;
	logic [lfu_pkg::IDX_W-1:0]   idx_s1;
	logic [lfu_pkg::ENTRY_W-1:0] rd_raw;
	lfu_pkg::lfu_entry_t         rd_ent;

	logic                        found_q;
	logic [lfu_pkg::IDX_W-1:0]   found_idx_q;
	logic [lfu_pkg::IDX_W-1:0]   found_rank_q;
	logic [lfu_pkg::VALUE_W-1:0] found_value_q;
	logic [lfu_pkg::COUNT_W-1:0] found_count_q;

	logic                        vic_have_q;
	logic [lfu_pkg::IDX_W-1:0]   vic_idx_q;
	logic [lfu_pkg::IDX_W-1:0]   vic_rank_q;
	logic [lfu_pkg::KEY_W-1:0]   vic_key_q;
	logic [lfu_pkg::COUNT_W-1:0] vic_count_q;

	logic [lfu_pkg::IDX_W-1:0]       cur_rank;
	logic [lfu_pkg::MAX_ENTRIES-1:0] valid_vec;
	logic [lfu_pkg::OCC_W-1:0]       occ;
	logic                            cur_valid;
	logic                            match;
	logic                            better;

	logic                            accept;
	logic                            commit;
	logic                            is_put;
	logic                            need_evict;
	logic [lfu_pkg::MAX_ENTRIES-1:0] free_vec;
	logic                            slot_ok;
	logic [lfu_pkg::IDX_W-1:0]       slot;
	logic [lfu_pkg::COUNT_W-1:0]     bumped;

	logic                            we;
	logic [lfu_pkg::IDX_W-1:0]       waddr;
	lfu_pkg::lfu_entry_t             wentry;
	lfu_pkg::lfu_rank_cmd_t          cmd;
	lfu_pkg::lfu_rsp_t               rsp_d;
	logic                            rsp_valid_q;
	lfu_pkg::lfu_rsp_t               rsp_q;

	lfu_entry_ram #(
		.DEPTH(lfu_pkg::MAX_ENTRIES),
		.WIDTH(lfu_pkg::ENTRY_W),
		.AW   (lfu_pkg::IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.re   (rd_en),
		.raddr(addr_q),
		.rdata(rd_raw)
	);

	lfu_rank_cells u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (commit),
		.cmd      (cmd),
		.rd_idx   (idx_s1),
		.rd_rank  (cur_rank),
		.valid    (valid_vec),
		.occupancy(occ)
	);

	assign rd_ent = rd_raw;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lfu_pkg::OCC_W'(1);
		end else if (cap_q > lfu_pkg::CAP_W'(lfu_pkg::MAX_ENTRIES)) begin
			eff_cap = lfu_pkg::OCC_W'(lfu_pkg::MAX_ENTRIES);
		end else begin
			eff_cap = lfu_pkg::OCC_W'(cap_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rd_en     = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			lfu_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = lfu_pkg::ST_SCAN;
				end
			end
			lfu_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (addr_q == lfu_pkg::IDX_W'(lfu_pkg::MAX_ENTRIES - 1)) begin
					state_d = lfu_pkg::ST_DRAIN;
				end
			end
			lfu_pkg::ST_DRAIN: begin
				state_d = lfu_pkg::ST_COMMIT;
			end
			lfu_pkg::ST_COMMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					commit  = 1'b1;
					state_d = lfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfu_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::ST_IDLE;
			cap_q   <= lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
			addr_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				addr_q <= '0;
			end else if (rd_en) begin
				addr_q <= addr_q + lfu_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= addr_q;
		end
		if (accept) begin
			req_q <= req;
		end
	end

	assign cur_valid = pend_s1 && valid_vec[idx_s1];
	assign match     = cur_valid && !found_q && (rd_ent.key == req_q.key);
	assign better    = cur_valid && (!vic_have_q || (rd_ent.count < vic_count_q) ||
		((rd_ent.count == vic_count_q) && (cur_rank < vic_rank_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			vic_have_q <= 1'b0;
		end else if (accept) begin
			found_q    <= 1'b0;
			vic_have_q <= 1'b0;
		end else begin
			if (match) begin
				found_q <= 1'b1;
			end
			if (better) begin
				vic_have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			found_idx_q   <= idx_s1;
			found_rank_q  <= cur_rank;
			found_value_q <= rd_ent.value;
			found_count_q <= rd_ent.count;
		end
		if (better) begin
			vic_idx_q   <= idx_s1;
			vic_rank_q  <= cur_rank;
			vic_key_q   <= rd_ent.key;
			vic_count_q <= rd_ent.count;
		end
	end

	assign is_put     = (req_q.action == lfu_pkg::ACT_PUT);
	assign need_evict = is_put && !found_q && (occ >= eff_cap) && vic_have_q;
	assign bumped     = (&found_count_q) ? found_count_q :
		(found_count_q + lfu_pkg::COUNT_W'(1));

	always_comb begin
		free_vec = ~valid_vec;
		if (need_evict) begin
			free_vec[vic_idx_q] = 1'b1;
		end
		slot_ok = 1'b0;
		slot    = '0;
		for (int j = lfu_pkg::MAX_ENTRIES - 1; j >= 0; j--) begin
			if (free_vec[j]) begin
				slot_ok = 1'b1;
				slot    = lfu_pkg::IDX_W'(j);
			end
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.touch_idx   = found_idx_q;
		cmd.touch_rank  = found_rank_q;
		cmd.remove_idx  = vic_idx_q;
		cmd.remove_rank = vic_rank_q;
		cmd.insert_idx  = slot;
		cmd.touch       = found_q;
		cmd.remove      = need_evict;
		cmd.insert      = is_put && !found_q && slot_ok;

		we           = 1'b0;
		waddr        = slot;
		wentry.key   = req_q.key;
		wentry.value = req_q.value;
		wentry.count = lfu_pkg::COUNT_W'(1);
		if (found_q) begin
			waddr        = found_idx_q;
			wentry.value = is_put ? req_q.value : found_value_q;
			wentry.count = bumped;
			we           = commit;
		end else if (is_put && slot_ok) begin
			we = commit;
		end

		rsp_d.hit         = found_q;
		rsp_d.read_value  = (found_q && !is_put) ? found_value_q : '0;
		rsp_d.evicted     = need_evict;
		rsp_d.evicted_key = need_evict ? vic_key_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(occ))
		else $error("Occupancy does not match the number of valid entries.");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= lfu_pkg::OCC_W'(lfu_pkg::MAX_ENTRIES))
		else $error("Occupancy exceeds the table depth.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("A new transaction was taken while one was in progress.");

	a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid)
		else $error("A committed transaction produced no response.");

	a_evict_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && need_evict) |-> (occ >= eff_cap))
		else $error("An eviction happened below capacity.");
`endif

endmodule
